// ===== rtl/core/pid_controller_top_assert.svh =====
// Assertion macros for the PID controller core.
// Uses clk and arst_n of the including module; no other dependencies.
`ifndef PID_CONTROLLER_TOP_ASSERT_SVH
`define PID_CONTROLLER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pid_pkg.sv =====
// Shared types, constants and saturation helper for the PID controller core.
// No dependencies.
`default_nettype none

package pid_pkg;

	localparam int DATA_W  = 32;
	localparam int COEF_W  = 31;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int FRAC_W  = 16;
	localparam int SHF_W   = PROD_W - FRAC_W;
	localparam int SATIN_W = SHF_W + 1;
	localparam int ACC_W   = SHF_W + 2;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P   = 3'd0,
		REG_GAIN_I   = 3'd1,
		REG_GAIN_D   = 3'd2,
		REG_LIMIT    = 3'd3,
		REG_TSTEP    = 3'd4,
		REG_INV_TSTEP = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_INT,
		ST_MUL_DER,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC_D,
		ST_CLAMP
	} pid_state_t;

	localparam logic signed [SATIN_W-1:0] SAT_MAX = SATIN_W'(64'sd2147483647);
	localparam logic signed [SATIN_W-1:0] SAT_MIN = SATIN_W'(-64'sd2147483648);

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SATIN_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[DATA_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pid_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on pid_pkg for operand and product widths.
`default_nettype none

module pid_mul
	import pid_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output      logic signed [PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

// ===== rtl/core/pid_controller_top.sv =====
// PID controller top level: config registers, sequencer, state and output register.
// Depends on pid_pkg, pid_mul and pid_controller_top_assert.svh.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | write in
//  in      | in_valid in_ready target measured clear_state | in
//  out     | out_valid out_ready drive clamped         | out
//
// One transaction runs from acceptance to the result register through the error
// step, five passes through the single shared 33x32 multiplier, one accumulate
// and the clamp. in_ready is high only in the idle state, so a new transaction
// waits until the last has left the clamp step. The result register lets the
// next transaction run while a result waits on out_ready; its clamp step stalls
// until the register frees. Reset clears state and loads defaults.
`default_nettype none

module pid_controller_top
	import pid_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [DATA_W-1:0]      cfg_data,
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	input  wire logic signed [DATA_W-1:0] target,
	input  wire logic signed [DATA_W-1:0] measured,
	input  wire logic                   clear_state,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      logic signed [DATA_W-1:0] drive,
	output      logic                   clamped
);

	logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [COEF_W-1:0]        limit_q, tstep_q, inv_tstep_q;

	pid_state_t state_q, state_d;

	logic signed [DATA_W-1:0] target_q, measured_q;
	logic                     clear_q;
	logic signed [DATA_W-1:0] err_q, integ_q, prev_q, deriv_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q, clamped_q;
	logic signed [DATA_W-1:0] drive_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SHF_W-1:0]   shf;
	logic signed [ACC_W-1:0]   shf_ext;
	logic signed [DATA_W:0]    err_wide, delta;
	logic signed [ACC_W-1:0]   lim_pos, lim_neg;
	logic                      out_free;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;
	assign out_free  = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			limit_q     <= COEF_W'(32'h7FFF_FFFF);
			tstep_q     <= COEF_W'(32'h0001_0000);
			inv_tstep_q <= COEF_W'(32'h0001_0000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:    gain_p_q    <= cfg_data;
				REG_GAIN_I:    gain_i_q    <= cfg_data;
				REG_GAIN_D:    gain_d_q    <= cfg_data;
				REG_LIMIT:     limit_q     <= cfg_data[COEF_W-1:0];
				REG_TSTEP:     tstep_q     <= cfg_data[COEF_W-1:0];
				REG_INV_TSTEP: inv_tstep_q <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_ERR;
			ST_ERR:     state_d = ST_MUL_INT;
			ST_MUL_INT: state_d = ST_MUL_DER;
			ST_MUL_DER: state_d = ST_MUL_P;
			ST_MUL_P:   state_d = ST_MUL_I;
			ST_MUL_I:   state_d = ST_MUL_D;
			ST_MUL_D:   state_d = ST_ACC_D;
			ST_ACC_D:   state_d = ST_CLAMP;
			ST_CLAMP:   if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and multiplier operand select
	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_MUL_INT: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed({1'b0, tstep_q});
			end
			ST_MUL_DER: begin
				mul_a = delta;
				mul_b = $signed({1'b0, inv_tstep_q});
			end
			ST_MUL_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = gain_p_q;
			end
			ST_MUL_I: begin
				mul_a = MUL_A_W'(integ_q);
				mul_b = gain_i_q;
			end
			ST_MUL_D: begin
				mul_a = MUL_A_W'(deriv_q);
				mul_b = gain_d_q;
			end
			default: ;
		endcase
	end

	pid_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// floor shift of the previous cycle's product
	assign shf      = prod_q[PROD_W-1:FRAC_W];
	assign shf_ext  = ACC_W'(shf);
	assign err_wide = (DATA_W+1)'(target_q) - (DATA_W+1)'(measured_q);
	assign delta    = (DATA_W+1)'(err_q) - (DATA_W+1)'(prev_q);
	assign lim_pos  = $signed({{(ACC_W-COEF_W){1'b0}}, limit_q});
	assign lim_neg  = -lim_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_ERR: begin
					if (clear_q) begin
						integ_q <= '0;
						prev_q  <= '0;
					end
				end
				ST_MUL_DER: integ_q <= sat32(SATIN_W'(integ_q) + SATIN_W'(shf));
				ST_MUL_P:   prev_q  <= err_q;
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			target_q   <= target;
			measured_q <= measured;
			clear_q    <= clear_state;
		end
		case (state_q)
			ST_ERR:   err_q   <= sat32(SATIN_W'(err_wide));
			ST_MUL_P: deriv_q <= sat32(SATIN_W'(shf));
			ST_MUL_I: acc_q   <= shf_ext;
			ST_MUL_D: acc_q   <= acc_q + shf_ext;
			ST_ACC_D: acc_q   <= acc_q + shf_ext;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_CLAMP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLAMP && out_free) begin
			if (acc_q > lim_pos) begin
				drive_q   <= lim_pos[DATA_W-1:0];
				clamped_q <= 1'b1;
			end else if (acc_q < lim_neg) begin
				drive_q   <= lim_neg[DATA_W-1:0];
				clamped_q <= 1'b1;
			end else begin
				drive_q   <= acc_q[DATA_W-1:0];
				clamped_q <= 1'b0;
			end
		end
	end

`include "pid_controller_top_assert.svh"

	`PID_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == ST_ERR && !in_ready, "accepted transaction did not start the sequence")
	`PID_ASSERT_NEXT(a_clamp_holds, state_q == ST_CLAMP && out_valid_q && !out_ready, state_q == ST_CLAMP, "sequencer left clamp step while result was pending")
	`PID_ASSERT_NOW(a_clamped_value, out_valid_q && clamped_q, drive_q == lim_pos[DATA_W-1:0] || drive_q == lim_neg[DATA_W-1:0], "clamped drive is not at the limit")
	`PID_ASSERT_NOW(a_inside_limit, out_valid_q && !clamped_q, ACC_W'(drive_q) <= lim_pos && ACC_W'(drive_q) >= lim_neg, "unclamped drive outside the limit")

endmodule

`default_nettype wire
